[src/sbt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_pkg
// Shared constants, types and the exponential table for the sponge taper.
// ----------------------------------------------------------------------------
package sbt_pkg;

	localparam int COORD_BITS      = 24;
	localparam int TAPER_FRAC_BITS = 16;
	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_BITS        = $clog2(EXP_TABLE_DEPTH);
	localparam int FB              = TAPER_FRAC_BITS;
	localparam int DB              = FB + 1;           // depth in [0, 2^F]
	localparam int NUM_BITS        = COORD_BITS + 1;
	localparam int QDIV_BITS       = COORD_BITS + FB;  // dividend width
	localparam int COEF_BITS       = 16;
	localparam int SBITS           = FB + 1;
	localparam int XBITS           = COEF_BITS + SBITS;
	localparam int TAB_BITS        = FB + 1;
	localparam int OUT_BITS        = 17;
	localparam int QDEPTH          = 4;
	localparam int QPTR_BITS       = $clog2(QDEPTH);

	// Q60 argument step of the table, 16 / depth.
	localparam logic [63:0] EXP_STEP = (64'd1 << 62) / EXP_TABLE_DEPTH * 4;

	localparam logic [2:0] REG_LEN_X  = 3'd0;
	localparam logic [2:0] REG_LEN_Y  = 3'd1;
	localparam logic [2:0] REG_LEN_Z  = 3'd2;
	localparam logic [2:0] REG_EXT_X  = 3'd3;
	localparam logic [2:0] REG_EXT_Y  = 3'd4;
	localparam logic [2:0] REG_EXT_Z  = 3'd5;
	localparam logic [2:0] REG_ENABLE = 3'd6;
	localparam logic [2:0] REG_COEFFS = 3'd7;

	// One axis after classification: clamped numerators of both sides.
	typedef struct packed {
		logic [NUM_BITS-1:0]   num_lo;
		logic [NUM_BITS-1:0]   num_hi;
		logic [COORD_BITS-1:0] len;
		logic [COEF_BITS-1:0]  coef;
	} axis_job_t;

	typedef struct packed {
		axis_job_t [2:0] axis;
	} job_t;

	function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah, al, bh, bl, mid, lo;
		ah  = a >> 30;
		al  = a & 64'h3FFF_FFFF;
		bh  = b >> 30;
		bl  = b & 64'h3FFF_FFFF;
		mid = ah * bl + al * bh;
		lo  = al * bl;
		return ah * bh + ((mid + (lo >> 30)) >> 30);
	endfunction

	// Long division by shift and subtract, used only while building the table.
	function automatic logic [63:0] udiv_const(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q, r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	typedef logic [TAB_BITS-1:0] tab_arr_t [EXP_TABLE_DEPTH+1];

	// Entry i holds exp(-16 i / depth) rounded to F fraction bits.
	function automatic tab_arr_t build_tab();
		tab_arr_t t;
		logic [63:0] term, ratio, v, half;
		term  = 64'd1 << 60;
		ratio = 64'd1 << 60;
		v     = 64'd1 << 60;
		half  = 64'd1 << (59 - FB);
		for (int k = 1; k <= 30; k++) begin
			term = udiv_const(q60_mul(term, EXP_STEP), 64'(k));
			if (k[0]) ratio = ratio - term;
			else ratio = ratio + term;
		end
		t[0] = TAB_BITS'((v + half) >> (60 - FB));
		for (int j = 1; j <= EXP_TABLE_DEPTH; j++) begin
			v    = q60_mul(v, ratio);
			t[j] = TAB_BITS'((v + half) >> (60 - FB));
		end
		return t;
	endfunction

	localparam tab_arr_t EXP_TAB = build_tab();

endpackage

[src/sbt_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_front
// Near tests and clamped sponge depth numerators for all three axes.
// ----------------------------------------------------------------------------
module sbt_front import sbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] centre_x,
	input  logic [COORD_BITS-1:0] centre_y,
	input  logic [COORD_BITS-1:0] centre_z,
	input  logic [COORD_BITS-1:0] node_x,
	input  logic [COORD_BITS-1:0] node_y,
	input  logic [COORD_BITS-1:0] node_z,
	input  logic [COORD_BITS-1:0] len [3],
	input  logic [COORD_BITS-1:0] ext [3],
	input  logic [5:0]            side_enable,
	input  logic [47:0]           coeffs,
	output logic                  job_valid,
	input  logic                  job_ready,
	output job_t                  job
);

	logic [COORD_BITS-1:0] cen [3];
	logic [COORD_BITS-1:0] nod [3];
	job_t job_d;
	job_t job_s1;
	logic valid_s1;

	assign cen[0] = centre_x;
	assign cen[1] = centre_y;
	assign cen[2] = centre_z;
	assign nod[0] = node_x;
	assign nod[1] = node_y;
	assign nod[2] = node_z;

	// A numerator clamped to [0, L]; zero when the side is not active.
	function automatic logic [NUM_BITS-1:0] clampn(input logic signed [NUM_BITS+1:0] n,
		input logic [COORD_BITS-1:0] l, input logic act);
		logic signed [NUM_BITS+1:0] ls;
		ls = $signed({3'b000, l});
		if (!act || n <= 0) return '0;
		if (n >= ls) return {1'b0, l};
		return n[NUM_BITS-1:0];
	endfunction

	always_comb begin
		logic signed [NUM_BITS+1:0] l, e, c, n, nlo, nhi;
		for (int a = 0; a < 3; a++) begin
			l   = $signed({3'b000, len[a]});
			e   = $signed({3'b000, ext[a]});
			c   = $signed({3'b000, cen[a]});
			n   = $signed({3'b000, nod[a]});
			nlo = l - n;
			nhi = l - (e - n);
			job_d.axis[a].num_lo = clampn(nlo, len[a], side_enable[2*a] && (c <= l));
			job_d.axis[a].num_hi = clampn(nhi, len[a], side_enable[2*a+1] && (c >= e - l));
			job_d.axis[a].len    = len[a];
			job_d.axis[a].coef   = coeffs[16*a +: 16];
		end
	end

	assign in_ready  = !valid_s1 || job_ready;
	assign job_valid = valid_s1;
	assign job       = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			job_s1 <= job_d;
		end
	end

endmodule

[src/sbt_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_queue
// Short queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module sbt_queue import sbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  job_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output job_t rd_data
);

	job_t mem_q [QDEPTH];
	logic [QPTR_BITS-1:0] wp_q, rp_q;
	logic [QPTR_BITS:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != QDEPTH[QPTR_BITS:0];
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 1'b1;
			if (rd) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_BITS+1)'(wr) - (QPTR_BITS+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

endmodule

[src/sbt_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbt_back
// Depth division, squaring, table lookup and minimum, as a stall pipeline.
// ----------------------------------------------------------------------------
module sbt_back import sbt_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  job_t                job,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_BITS-1:0] taper
);

	// Divider: restoring, one quotient bit per stage, six values in parallel.
	localparam int NST = QDIV_BITS;
	localparam int NV  = 6;
	localparam int PS  = NST + 5; // + square, mult, lookup, interp, min

	logic [PS:0] v;
	logic        adv;

	assign adv       = !v[PS] || out_ready;
	assign job_ready = adv;
	assign out_valid = v[PS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (adv) begin
			v <= {v[PS-1:0], job_valid};
		end
	end

	logic [COORD_BITS:0]   rem_q [NST+1][NV];
	logic [QDIV_BITS-1:0]  quo_q [NST+1][NV];
	logic [COORD_BITS-1:0] dl_q  [NST+1][3];
	logic [COEF_BITS-1:0]  cf_q  [NST+1][3];
	logic                  full_q [NST+1][NV];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				rem_q[0][2*a]   <= '0;
				rem_q[0][2*a+1] <= '0;
				quo_q[0][2*a]   <= {job.axis[a].num_lo[COORD_BITS-1:0], FB'(0)};
				quo_q[0][2*a+1] <= {job.axis[a].num_hi[COORD_BITS-1:0], FB'(0)};
				full_q[0][2*a]  <= job.axis[a].num_lo[COORD_BITS];
				full_q[0][2*a+1]<= job.axis[a].num_hi[COORD_BITS];
				dl_q[0][a]      <= job.axis[a].len;
				cf_q[0][a]      <= job.axis[a].coef;
			end
			for (int s = 0; s < NST; s++) begin
				for (int k = 0; k < NV; k++) begin
					logic [COORD_BITS+1:0] r;
					r = {rem_q[s][k], quo_q[s][k][QDIV_BITS-1]};
					if (r >= {2'b00, dl_q[s][k/2]}) begin
						rem_q[s+1][k] <= (COORD_BITS+1)'(r - {2'b00, dl_q[s][k/2]});
						quo_q[s+1][k] <= {quo_q[s][k][QDIV_BITS-2:0], 1'b1};
					end else begin
						rem_q[s+1][k] <= r[COORD_BITS:0];
						quo_q[s+1][k] <= {quo_q[s][k][QDIV_BITS-2:0], 1'b0};
					end
					full_q[s+1][k] <= full_q[s][k];
				end
				for (int a = 0; a < 3; a++) begin
					dl_q[s+1][a] <= dl_q[s][a];
					cf_q[s+1][a] <= cf_q[s][a];
				end
			end
		end
	end

	// The clamp keeps num <= L, so num == L already yields 2^F. A zero sponge
	// length gives no depth, whatever the divider made of zero over zero.
	logic [DB-1:0]         d_c [3];
	logic [SBITS-1:0]      s_s2 [3];
	logic [COEF_BITS-1:0]  cf_s2 [3];
	logic [XBITS+IDX_BITS-1:0] p_s3 [3];
	logic [TAB_BITS-1:0]   t0_s4 [3], t1_s4 [3];
	logic [FB-1:0]         f_s4 [3];
	logic                  sat_s4 [3];
	logic [TAB_BITS-1:0]   tv_s5 [3];
	logic [OUT_BITS-1:0]   out_s6;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			logic [QDIV_BITS-1:0] q0, q1;
			q0 = quo_q[NST][2*a];
			q1 = quo_q[NST][2*a+1];
			if (full_q[NST][2*a]) q0 = QDIV_BITS'(1 << FB);
			if (full_q[NST][2*a+1]) q1 = QDIV_BITS'(1 << FB);
			if (dl_q[NST][a] == '0) begin
				q0 = '0;
				q1 = '0;
			end
			d_c[a] = DB'((q0 > q1) ? q0 : q1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				logic [2*DB-1:0] sq;
				logic [XBITS+IDX_BITS-1:0] pp;
				logic [XBITS+IDX_BITS-1:0] tmp;
				logic [IDX_BITS:0] ix;
				logic [TAB_BITS+FB-1:0] dp;
				sq = d_c[a] * d_c[a];
				s_s2[a]  <= SBITS'(sq >> FB);
				cf_s2[a] <= cf_q[NST][a];
				pp = (XBITS+IDX_BITS)'(cf_s2[a]) * (XBITS+IDX_BITS)'(s_s2[a]);
				p_s3[a] <= pp << IDX_BITS;
				tmp = p_s3[a] >> (16 + FB);
				ix  = (IDX_BITS+1)'(tmp);
				sat_s4[a] <= tmp >= EXP_TABLE_DEPTH;
				t0_s4[a]  <= EXP_TAB[ix];
				t1_s4[a]  <= EXP_TAB[ix + 1'b1];
				f_s4[a]   <= FB'(p_s3[a] >> 16);
				dp = (TAB_BITS+FB)'(t0_s4[a] - t1_s4[a]) * (TAB_BITS+FB)'(f_s4[a]);
				if (sat_s4[a]) begin
					tv_s5[a] <= EXP_TAB[EXP_TABLE_DEPTH];
				end else begin
					tv_s5[a] <= t0_s4[a] - TAB_BITS'(dp >> FB);
				end
			end
			begin
				logic [TAB_BITS-1:0] m;
				m = TAB_BITS'(1 << FB);
				for (int a = 0; a < 3; a++) begin
					if (tv_s5[a] < m) m = tv_s5[a];
				end
				out_s6 <= OUT_BITS'(m);
			end
		end
	end

	assign taper = out_s6;

endmodule

[src/sponge_boundary_taper.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sponge_boundary_taper
// Cerjan sponge damping factor for one mesh node per transaction.
// ----------------------------------------------------------------------------
// One node is accepted per cycle while in_ready is high, and its taper passes
// through the front register, the queue and the bit-per-stage depth divider
// of the back pipeline; a four-entry queue separates the classifying front
// from the back so either side may stall on its own.
module sponge_boundary_taper import sbt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] centre_x,
	input  logic [COORD_BITS-1:0] centre_y,
	input  logic [COORD_BITS-1:0] centre_z,
	input  logic [COORD_BITS-1:0] node_x,
	input  logic [COORD_BITS-1:0] node_y,
	input  logic [COORD_BITS-1:0] node_z,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_BITS-1:0]   taper,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [47:0]           cfg_data
);

	logic [COORD_BITS-1:0] len_q [3];
	logic [COORD_BITS-1:0] ext_q [3];
	logic [5:0]  en_q;
	logic [47:0] coef_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				len_q[a] <= COORD_BITS'(256);
				ext_q[a] <= '1;
			end
			en_q   <= '0;
			coef_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LEN_X:  len_q[0] <= cfg_data[COORD_BITS-1:0];
				REG_LEN_Y:  len_q[1] <= cfg_data[COORD_BITS-1:0];
				REG_LEN_Z:  len_q[2] <= cfg_data[COORD_BITS-1:0];
				REG_EXT_X:  ext_q[0] <= cfg_data[COORD_BITS-1:0];
				REG_EXT_Y:  ext_q[1] <= cfg_data[COORD_BITS-1:0];
				REG_EXT_Z:  ext_q[2] <= cfg_data[COORD_BITS-1:0];
				REG_ENABLE: en_q     <= cfg_data[5:0];
				REG_COEFFS: coef_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic f_valid, f_ready, b_valid, b_ready;
	job_t f_job, b_job;

	sbt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.centre_x(centre_x), .centre_y(centre_y), .centre_z(centre_z),
		.node_x(node_x), .node_y(node_y), .node_z(node_z),
		.len(len_q), .ext(ext_q), .side_enable(en_q), .coeffs(coef_q),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	sbt_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_job), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
	);

	sbt_back u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(b_valid), .job_ready(b_ready),
		.job(b_job), .out_valid(out_valid), .out_ready(out_ready), .taper(taper)
	);

`ifndef SYNTH
	a_taper_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> taper <= OUT_BITS'(1 << FB))
		else $error("taper above one");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(taper))
		else $error("result changed while stalled");
`endif

endmodule

[tb/sv/sponge_boundary_taper_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sponge_boundary_taper_tb
// Self-checking bench for the sponge taper: a directed table of nodes, then
// random nodes under several register settings, with random gaps on both
// channels; every taper is compared in order against a local predictor.
// ----------------------------------------------------------------------------
module sponge_boundary_taper_tb;
	import sbt_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int DRAIN    = COORD_BITS + TAPER_FRAC_BITS + 20;
	localparam logic [16:0] NO_CHECK = 17'h1FFFF;

	typedef logic [COORD_BITS-1:0] coord_t;

	typedef struct {
		coord_t cx, cy, cz, nx, ny, nz;
		logic [16:0] want;
	} node_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
	coord_t centre_x, centre_y, centre_z, node_x, node_y, node_z;
	logic [OUT_BITS-1:0] taper;
	logic [2:0] cfg_index;
	logic [47:0] cfg_data;

	sponge_boundary_taper dut (.*);

	// Predictor copy of the registers and the exponential table.
	logic [63:0] len_r [3];
	logic [63:0] ext_r [3];
	logic [5:0] enable_r;
	logic [47:0] coeffs_r;
	logic [63:0] exp_lut [EXP_TABLE_DEPTH+1];

	logic [16:0] taper_q [$];
	int errors = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit hold_off = 0;

	function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
		logic [63:0] ah, al, bh, bl;
		ah = a >> 30;
		al = a & 64'h3FFF_FFFF;
		bh = b >> 30;
		bl = b & 64'h3FFF_FFFF;
		return ah * bh + (((ah * bl + al * bh) + ((al * bl) >> 30)) >> 30);
	endfunction

	task automatic fill_exp_lut();
		logic [63:0] stp, term, ratio, v, half;
		stp = (64'd1 << 62) / EXP_TABLE_DEPTH * 4;
		term = 64'd1 << 60;
		ratio = term;
		v = term;
		half = 64'd1 << (59 - TAPER_FRAC_BITS);
		for (int k = 1; k <= 30; k++) begin
			term = mul_q60(term, stp) / k;
			if (k % 2) ratio -= term;
			else ratio += term;
		end
		exp_lut[0] = (v + half) >> (60 - TAPER_FRAC_BITS);
		for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
			v = mul_q60(v, ratio);
			exp_lut[i] = (v + half) >> (60 - TAPER_FRAC_BITS);
		end
	endtask

	function automatic logic [63:0] depth_of(longint num, logic [63:0] l);
		if (l == 0 || num <= 0) return 0;
		if (64'(num) >= l) return 64'd1 << TAPER_FRAC_BITS;
		return (64'(num) << TAPER_FRAC_BITS) / l;
	endfunction

	function automatic logic [63:0] axis_damping(int a, coord_t c, coord_t n);
		logic [63:0] l, e, coef, d, t, s, p, idx, f, t0, t1;
		l = len_r[a];
		e = ext_r[a];
		coef = (coeffs_r >> (16 * a)) & 16'hFFFF;
		d = 0;
		if (enable_r[2*a] && c <= l) begin
			t = depth_of(longint'(l) - longint'(n), l);
			if (t > d) d = t;
		end
		if (enable_r[2*a+1] && longint'(c) >= longint'(e) - longint'(l)) begin
			t = depth_of(longint'(l) - (longint'(e) - longint'(n)), l);
			if (t > d) d = t;
		end
		s = (d * d) >> TAPER_FRAC_BITS;
		p = coef * s * EXP_TABLE_DEPTH;
		idx = p >> (16 + TAPER_FRAC_BITS);
		if (idx >= EXP_TABLE_DEPTH) return exp_lut[EXP_TABLE_DEPTH];
		f = (p & ((64'd1 << (16 + TAPER_FRAC_BITS)) - 1)) >> 16;
		t0 = exp_lut[idx];
		t1 = exp_lut[idx+1];
		return t0 - (((t0 - t1) * f) >> TAPER_FRAC_BITS);
	endfunction

	function automatic logic [16:0] node_taper(coord_t cx, cy, cz, nx, ny, nz);
		logic [63:0] best, t;
		best = 64'd1 << TAPER_FRAC_BITS;
		t = axis_damping(0, cx, nx); if (t < best) best = t;
		t = axis_damping(1, cy, ny); if (t < best) best = t;
		t = axis_damping(2, cz, nz); if (t < best) best = t;
		return best[16:0];
	endfunction

	function automatic int gap_len();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("sponge_boundary_taper_tb: errors");
			$finish;
		end
	end

	// Receiver: random stalls, plus one long hold-off requested by the sender.
	initial begin
		int g;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 0;
				repeat (150) @(posedge clk);
				hold_off = 0;
			end
			g = gap_len();
			if (g > 0) begin
				out_ready <= 0;
				repeat (g) @(posedge clk);
			end
			out_ready <= 1;
			@(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (taper_q.size() == 0) begin
				$error("taper: unexpected transaction, actual %0d", taper);
				errors++;
			end else begin
				logic [16:0] w;
				w = taper_q.pop_front();
				if (taper !== w) begin
					$error("taper: expected %0d actual %0d", w, taper);
					errors++;
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (idx)
			REG_LEN_X, REG_LEN_Y, REG_LEN_Z: len_r[idx] = val[COORD_BITS-1:0];
			REG_EXT_X, REG_EXT_Y, REG_EXT_Z: ext_r[idx-3] = val[COORD_BITS-1:0];
			REG_ENABLE: enable_r = val[5:0];
			default: coeffs_r = val;
		endcase
		@(posedge clk);
	endtask

	// Drives one node; a row want other than NO_CHECK is also checked
	// against the predictor so the typed value is not trusted blindly.
	task automatic send_node(node_row_t r, bit gaps);
		logic [16:0] p;
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		p = node_taper(r.cx, r.cy, r.cz, r.nx, r.ny, r.nz);
		if (r.want != NO_CHECK && r.want != p) begin
			$error("taper: table expected %0d predictor %0d", r.want, p);
			errors++;
		end
		in_valid <= 1;
		centre_x <= r.cx; centre_y <= r.cy; centre_z <= r.cz;
		node_x <= r.nx; node_y <= r.ny; node_z <= r.nz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		taper_q.push_back(p);
	endtask

	task automatic drain_out();
		in_valid <= 0;
		while (taper_q.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	function automatic coord_t rnd_coord(logic [63:0] l, logic [63:0] e);
		case ($urandom_range(0, 5))
			0: return coord_t'($urandom_range(0, 16777215));
			1, 2: return (l > 1) ? coord_t'($urandom_range(0, l[23:0] + 4)) :
				coord_t'($urandom_range(0, 4));
			3, 4: return (e > l + 4) ? coord_t'($urandom_range(e - l - 4, e)) :
				coord_t'($urandom_range(0, e));
			default: return $urandom_range(0, 1) ? coord_t'(0) : 24'hFFFFFF;
		endcase
	endfunction

	function automatic node_row_t rnd_node();
		node_row_t r;
		r.cx = rnd_coord(len_r[0], ext_r[0]);
		r.cy = rnd_coord(len_r[1], ext_r[1]);
		r.cz = rnd_coord(len_r[2], ext_r[2]);
		r.nx = rnd_coord(len_r[0], ext_r[0]);
		r.ny = rnd_coord(len_r[1], ext_r[1]);
		r.nz = rnd_coord(len_r[2], ext_r[2]);
		r.want = NO_CHECK;
		return r;
	endfunction

	initial begin
		node_row_t dir_tab [$];
		in_valid = 0;
		cfg_valid = 0;
		cfg_index = REG_LEN_X;
		cfg_data = 0;
		{centre_x, centre_y, centre_z, node_x, node_y, node_z} = '0;
		for (int a = 0; a < 3; a++) begin
			len_r[a] = 256;
			ext_r[a] = 24'hFFFFFF;
		end
		enable_r = 0;
		coeffs_r = 0;
		fill_exp_lut();
		@(posedge arst_n);
		@(posedge clk);

		// After reset every side is off: no damping at all.
		send_node('{0, 0, 0, 0, 0, 0, 17'h10000}, 0);
		send_node('{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 17'h10000}, 0);
		drain_out();

		// All sides on, largest coefficient, small domain.
		write_reg(REG_LEN_X, 100);
		write_reg(REG_LEN_Y, 200);
		write_reg(REG_LEN_Z, 1);
		write_reg(REG_EXT_X, 1000);
		write_reg(REG_EXT_Y, 150);
		write_reg(REG_EXT_Z, 0);
		write_reg(REG_ENABLE, 6'h3F);
		write_reg(REG_COEFFS, 48'hFFFF_FFFF_FFFF);
		dir_tab = '{
			'{0, 0, 0, 0, 0, 0, NO_CHECK},
			'{50, 500, 500, 50, 500, 500, NO_CHECK},
			'{100, 75, 0, 100, 75, 0, NO_CHECK},
			'{101, 75, 0, 0, 75, 0, NO_CHECK},
			'{900, 75, 0, 1000, 75, 0, NO_CHECK},
			'{950, 0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, NO_CHECK},
			'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0, 0, NO_CHECK},
			'{500, 140, 0, 500, 149, 1, NO_CHECK},
			'{500, 10, 0, 500, 0, 0, NO_CHECK},
			'{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 24'h555555, 24'hAAAAAA,
				24'h555555, NO_CHECK}
		};
		foreach (dir_tab[i]) send_node(dir_tab[i], 0);
		drain_out();

		// Zero sponge length: near test passes but gives no damping.
		write_reg(REG_LEN_X, 48'hFF00_0000);
		write_reg(REG_ENABLE, 6'h03);
		send_node('{0, 0, 0, 0, 0, 0, 17'h10000}, 0);
		drain_out();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 6; ph++) begin
			for (int a = 0; a < 3; a++) begin
				logic [47:0] l, e;
				l = (ph == 5) ? 24'hFFFFFF : ($urandom_range(0, 3) == 0 ?
					$urandom_range(0, 16777215) : $urandom_range(1, 4096));
				if (ph == 0) l = 1;
				e = (ph == 5) ? 0 : ($urandom_range(0, 3) == 0 ?
					$urandom_range(0, 16777215) : $urandom_range(0, 20000));
				write_reg(3'(REG_LEN_X + a), {24'($urandom_range(0, 255)), l[23:0]});
				write_reg(3'(REG_EXT_X + a), {24'($urandom_range(0, 255)), e[23:0]});
			end
			write_reg(REG_ENABLE, (ph == 1) ? 6'h0F : 6'($urandom_range(0, 63)) | 6'h21);
			write_reg(REG_COEFFS, (ph == 2) ? 48'h0 :
				{16'($urandom), 16'($urandom), 16'($urandom)});
			// Back-to-back phase: the long receiver hold-off fills the block.
			for (int i = 0; i < 90; i++) begin
				if (ph == 4 && i == 5) hold_off = 1;
				send_node(rnd_node(), ph != 4);
			end
			drain_out();
		end

		stim_done = 1;
		if (errors == 0) $display("sponge_boundary_taper_tb: clean");
		else $display("sponge_boundary_taper_tb: errors");
		$finish;
	end

	final if (taper_q.size() != 0 && !stim_done) errors++;

endmodule
